// File: rtl/bm3_pkg.sv
`timescale 1ns / 1ps

package bm3_pkg;

  // mask pixel levels
  localparam logic [7:0] PIX_SET = 8'd255;
  localparam logic [7:0] PIX_CLR = 8'd0;

  // op_select code for dilation, anything else erodes
  localparam logic OP_DILATE = 1'b1;

  // item mode code for a flush word
  localparam logic MODE_FLUSH = 1'b1;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;
  localparam logic [CFG_AW-1:0] REG_OP_SELECT    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd2;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // classified word handed from front to back
  typedef struct packed {
    logic       emit;   // this word produces a result
    logic       up;     // neighbor row above is in frame
    logic       down;   // neighbor row below is in frame
    logic       left;   // neighbor column to the left is in frame
    logic       right;  // neighbor column to the right is in frame
    logic       last;   // result closes the frame
    logic [7:0] pix;    // pixel shifted into the window, zero while draining
  } bm3_task_t;

endpackage

// File: rtl/bm3_queue.sv
`timescale 1ns / 1ps

module bm3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNTW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/bm3_front.sv
`timescale 1ns / 1ps

module bm3_front
  import bm3_pkg::*;
#(
  parameter int CW = 10,
  parameter int RW = 12,
  parameter int PW = 11,
  parameter int PH = 13
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [PW-1:0]   width,
  input  logic [PH-1:0]   height,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_mode,
  input  logic [7:0]      in_pixel,
  output logic            push,
  output bm3_task_t       push_task,
  output logic [CW-1:0]   push_col,
  input  logic            push_ready
);

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;

  logic [PW-1:0] in_col_x, out_col_x;
  logic [PH-1:0] in_row_x, out_row_x;
  logic          accept, drain, skip, emit, col_wrap;
  logic          up, down, left, right, last;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  assign in_col_x  = {{(PW - CW){1'b0}}, in_col_r};
  assign out_col_x = {{(PW - CW){1'b0}}, out_col_r};
  assign in_row_x  = {{(PH - RW){1'b0}}, in_row_r};
  assign out_row_x = {{(PH - RW){1'b0}}, out_row_r};

  // classify the word
  assign drain    = (in_row_x >= height);
  assign skip     = !drain && (in_mode == MODE_FLUSH);
  assign emit     = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign col_wrap = ((in_col_x + PW'(1)) >= width);

  // neighborhood of the result position
  assign up    = (out_row_r != '0);
  assign down  = ((out_row_x + PH'(1)) < height);
  assign left  = (out_col_r != '0);
  assign right = ((out_col_x + PW'(1)) < width);
  assign last  = !down && !right;

  assign push             = accept && !skip;
  assign push_col         = in_col_r;
  assign push_task.emit   = emit;
  assign push_task.up     = up;
  assign push_task.down   = down;
  assign push_task.left   = left;
  assign push_task.right  = right;
  assign push_task.last   = last;
  assign push_task.pix    = drain ? PIX_CLR : in_pixel;

  // position counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (push) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (!right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

// File: rtl/bm3_back.sv
`timescale 1ns / 1ps

module bm3_back
  import bm3_pkg::*;
#(
  parameter int CW    = 10,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_select,
  input  logic          q_valid,
  input  bm3_task_t     q_task,
  input  logic [CW-1:0] q_col,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_pixel,
  output logic          out_frame_last
);

  // line store word: upper line in the high byte, middle line in the low byte
  logic [15:0]   line_mem [DEPTH];
  logic [15:0]   rd_r;
  logic          fwd_v_r;
  logic [15:0]   fwd_d_r;

  logic          s1_v_r, s1_v_nxt;
  bm3_task_t     s1_task_r;
  logic [CW-1:0] s1_col_r;

  logic [7:0]    win_r [9];
  logic [7:0]    win_nxt [9];
  logic [15:0]   lines;
  logic          s1_adv;

  logic          out_v_r, out_v_nxt;
  logic [7:0]    out_pix_r;
  logic          out_last_r;

  logic [7:0]    seek, keep, center, result;
  logic [2:0]    row_ok, col_ok;
  logic          hit;

  assign out_valid      = out_v_r;
  assign out_pixel      = out_pix_r;
  assign out_frame_last = out_last_r;

  // stage handshake
  assign s1_adv = s1_v_r && (!s1_task_r.emit || !out_v_r || out_ready);
  assign q_pop  = q_valid && (!s1_v_r || s1_adv);

  // line data, bypassing a write to the same column that lands as the read is taken
  assign lines = fwd_v_r ? fwd_d_r : rd_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (q_pop) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (q_pop) begin
        fwd_v_r <= s1_adv && (s1_col_r == q_col);
      end
    end
  end

  // stage payload and bypass data
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_task_r <= q_task;
      s1_col_r  <= q_col;
      fwd_d_r   <= {lines[7:0], s1_task_r.pix};
    end
  end

  // line store read port
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= line_mem[q_col];
    end
  end

  // line store write port: middle moves up, new pixel enters the middle
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col_r] <= {lines[7:0], s1_task_r.pix};
    end
  end

  // window shift, new column on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r * 3]     = win_r[r * 3 + 1];
      win_nxt[r * 3 + 1] = win_r[r * 3 + 2];
    end
    win_nxt[2] = lines[15:8];
    win_nxt[5] = lines[7:0];
    win_nxt[8] = s1_task_r.pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= PIX_CLR;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // erosion or dilation over the in-frame neighbors
  assign seek   = (op_select == OP_DILATE) ? PIX_SET : PIX_CLR;
  assign keep   = (op_select == OP_DILATE) ? PIX_CLR : PIX_SET;
  assign center = win_nxt[4];
  assign row_ok = {s1_task_r.down, 1'b1, s1_task_r.up};
  assign col_ok = {s1_task_r.right, 1'b1, s1_task_r.left};

  always_comb begin
    hit = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c] && (win_nxt[r * 3 + c] == seek)) begin
          hit = 1'b1;
        end
      end
    end
    result = ((center == keep) && hit) ? seek : center;
  end

  // result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv && s1_task_r.emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_task_r.emit) begin
      out_pix_r  <= result;
      out_last_r <= s1_task_r.last;
    end
  end

endmodule

// File: rtl/binary_morphology_3x3_stream.sv
`timescale 1ns / 1ps
// 3x3 binary erosion / dilation on a raster mask stream, one word per clock sustained while out_ready holds.
// A result is registered in the back after the word that completes its window is popped; that word
// arrives frame_width+1 words after the pixel itself, and frame_width+1 flush words drain a frame.
// Throughput is set by the single line store, one read and one write per cycle.
// Synchronous active-low reset clears counters, queue, window and output valid and loads the
// register defaults; the line store is not cleared.

module binary_morphology_3x3_stream
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [7:0]        in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel,
  output logic              out_frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT) + 2;
  localparam int PW = (CW + 1 > CFG_DW) ? CW + 1 : CFG_DW;
  localparam int PH = (RW + 1 > CFG_DW) ? RW + 1 : CFG_DW;
  localparam int QW = $bits(bm3_task_t) + CW;

  // size clamping: zero acts as one, large values act as the maximum
  function automatic logic [PW-1:0] clamp_w(input logic [CFG_DW-1:0] v);
    logic [PW-1:0] vx;
    vx = PW'(v);
    if (v == '0) begin
      clamp_w = PW'(1);
    end else if (vx > PW'(MAX_WIDTH)) begin
      clamp_w = PW'(MAX_WIDTH);
    end else begin
      clamp_w = vx;
    end
  endfunction

  function automatic logic [PH-1:0] clamp_h(input logic [CFG_DW-1:0] v);
    logic [PH-1:0] vx;
    vx = PH'(v);
    if (v == '0) begin
      clamp_h = PH'(1);
    end else if (vx > PH'(MAX_HEIGHT)) begin
      clamp_h = PH'(MAX_HEIGHT);
    end else begin
      clamp_h = vx;
    end
  endfunction

  logic          op_r;
  logic [PW-1:0] width_r;
  logic [PH-1:0] height_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= 1'b0;
      width_r  <= clamp_w(CFG_DW'(640));
      height_r <= clamp_h(CFG_DW'(480));
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OP_SELECT:    op_r     <= cfg_wdata[0];
        REG_FRAME_WIDTH:  width_r  <= clamp_w(cfg_wdata);
        REG_FRAME_HEIGHT: height_r <= clamp_h(cfg_wdata);
        default: ;
      endcase
    end
  end

  logic          push, push_ready, q_valid, q_pop;
  bm3_task_t     push_task, q_task;
  logic [CW-1:0] push_col, q_col;
  logic [QW-1:0] q_data;

  // front: position tracking and classification
  bm3_front #(
    .CW(CW),
    .RW(RW),
    .PW(PW),
    .PH(PH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .width     (width_r),
    .height    (height_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_pixel  (in_pixel),
    .push      (push),
    .push_task (push_task),
    .push_col  (push_col),
    .push_ready(push_ready)
  );

  // decoupling queue
  bm3_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_task, push_col}),
    .push_ready(push_ready),
    .pop       (q_pop),
    .pop_data  (q_data),
    .pop_valid (q_valid)
  );

  assign q_task = q_data[QW-1:CW];
  assign q_col  = q_data[CW-1:0];

  // back: line stores, window and morphology
  bm3_back #(
    .CW   (CW),
    .DEPTH(MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_select     (op_r),
    .q_valid       (q_valid),
    .q_task        (q_task),
    .q_col         (q_col),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel),
    .out_frame_last(out_frame_last)
  );

endmodule

// File: bench/morph_monitor.sv
`timescale 1ns / 1ps

module morph_monitor
  import bm3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_mode,
  input  logic [7:0]        in_pixel,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_pixel,
  input  logic              out_frame_last,
  output int unsigned       fail_count,
  output int unsigned       open_count,
  output int unsigned       result_count
);

  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned ROWS_MAX = 1024;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } morph_word_t;

  // shadow registers
  logic        op_sel;
  logic [10:0] width_reg;
  logic [10:0] height_reg;

  // shadow line stores, window and raster positions
  logic [7:0]  line_above [LINE_MAX];
  logic [7:0]  line_center [LINE_MAX];
  logic [7:0]  win [9];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned res_col;
  int unsigned res_row;
  int unsigned drained;

  morph_word_t expected_px [$];
  morph_word_t want;

  // zero acts as one, oversize acts as the maximum
  function automatic int unsigned eff_size(logic [10:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // erode or dilate the window center, neighbors outside the frame are skipped
  function automatic logic [7:0] morph_center(int unsigned w, int unsigned h);
    logic [7:0] seek;
    logic [7:0] keep;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    seek = (op_sel == OP_DILATE) ? PIX_SET : PIX_CLR;
    keep = (op_sel == OP_DILATE) ? PIX_CLR : PIX_SET;
    row_ok = {res_row + 1 < h, 1'b1, res_row >= 1};
    col_ok = {res_col + 1 < w, 1'b1, res_col >= 1};
    if (win[4] != keep) return win[4];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c] && win[r*3+c] == seek) return seek;
      end
    end
    return win[4];
  endfunction

  // advance the shadow pipeline by one accepted word
  task automatic morph_step(logic mode, logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    logic        drain;
    logic        emit;
    logic [7:0]  top;
    logic [7:0]  mid;
    morph_word_t res;
    w = eff_size(width_reg, LINE_MAX);
    h = eff_size(height_reg, ROWS_MAX);
    drain = in_row >= h;
    // flush before the frame is complete does nothing
    if (!drain && mode == MODE_FLUSH) return;
    if (drain) begin
      pix = PIX_CLR;
      drained++;
    end
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);

    col = in_col % LINE_MAX;
    top = line_above[col];
    mid = line_center[col];
    line_above[col] = mid;
    line_center[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;

    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end

    if (emit) begin
      res.pix = morph_center(w, h);
      res.last = (res_row + 1 >= h) && (res_col + 1 >= w);
      expected_px.push_back(res);
      if (res.last) begin
        in_col = 0;
        in_row = 0;
        res_col = 0;
        res_row = 0;
        drained = 0;
      end else if (res_col + 1 >= w) begin
        res_col = 0;
        res_row++;
      end else begin
        res_col++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      op_sel = 1'b0;
      width_reg = 11'd640;
      height_reg = 11'd480;
      for (int i = 0; i < LINE_MAX; i++) begin
        line_above[i] = '0;
        line_center[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_col = 0;
      in_row = 0;
      res_col = 0;
      res_row = 0;
      drained = 0;
      expected_px.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_OP_SELECT:    op_sel = cfg_wdata[0];
          REG_FRAME_WIDTH:  width_reg = cfg_wdata;
          REG_FRAME_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && in_ready) morph_step(in_mode, in_pixel);

      // compare each result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          fail_count++;
          $error("out_pixel: no word expected, got %0d", out_pixel);
        end else begin
          want = expected_px.pop_front();
          result_count++;
          if (out_pixel !== want.pix) begin
            fail_count++;
            $error("out_pixel: expected %0d, got %0d", want.pix, out_pixel);
          end
          if (out_frame_last !== want.last) begin
            fail_count++;
            $error("out_frame_last: expected %0d, got %0d", want.last, out_frame_last);
          end
        end
      end
    end
    open_count = expected_px.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import bm3_pkg::*;

  localparam logic        OP_ERODE      = ~OP_DILATE;
  localparam logic        MODE_PIXEL    = ~MODE_FLUSH;
  localparam int unsigned SIZE_MAX      = 1024;
  localparam int unsigned RANDOM_PIXELS = 250;
  localparam int unsigned SETTLE        = 10;
  localparam int unsigned STUCK_LIMIT   = 2000;

  // 3x3 erosion frame: kept corner, eroded pixels, values that pass through
  localparam logic [71:0] ERODE_PAT = {8'd255, 8'd255, 8'd128,
                                       8'd255, 8'd255, 8'd0,
                                       8'd127, 8'd254, 8'd255};
  // 4x3 dilation frame: untouched zeros, grown set pixel, pass-through values
  localparam logic [95:0] DILATE_PAT = {8'd0,  8'd0, 8'd0, 8'd0,
                                        8'd0,  8'd0, 8'd0, 8'd255,
                                        8'd77, 8'd0, 8'd0, 8'd1};

  typedef enum logic [1:0] {PH_STEADY, PH_SLOW_SRC, PH_SLOW_SINK, PH_BOTH} phase_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_mode;
  logic [7:0]        in_pixel;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_pixel;
  logic              out_frame_last;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned result_count;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned eff_w;
  int unsigned eff_h;
  int unsigned frames = 0;
  int unsigned pixels_sent = 0;
  int unsigned flushes_sent = 0;
  int unsigned stuck = 0;
  int unsigned pixel_goal;
  logic        op_raw;
  logic [10:0] w_raw;
  logic [10:0] h_raw;

  binary_morphology_3x3_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

  morph_monitor mon (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function automatic logic [7:0] rand_mask();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return PIX_CLR;
    if (r < 90) return PIX_SET;
    return 8'($urandom_range(255));
  endfunction

  task automatic set_phase(phase_t p);
    case (p)
      PH_STEADY:    begin gap_pct = 0;  stall_pct = 0;  end
      PH_SLOW_SRC:  begin gap_pct = 81; stall_pct = 0;  end
      PH_SLOW_SINK: begin gap_pct = 0;  stall_pct = 81; end
      default:      begin gap_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic set_config(logic op, logic [10:0] w, logic [10:0] h);
    write_reg(REG_OP_SELECT, CFG_DW'(op));
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
    eff_w = (w == 0) ? 1 : ((w > SIZE_MAX) ? SIZE_MAX : w);
    eff_h = (h == 0) ? 1 : ((h > SIZE_MAX) ? SIZE_MAX : h);
  endtask

  // present one word, hold it until taken, return at the next falling edge
  task automatic send_word(logic mode, logic [7:0] pix);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (mode == MODE_FLUSH) flushes_sent++;
    else pixels_sent++;
  endtask

  task automatic send_pixels(int unsigned n, bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      // early flush, ignored while the frame is incomplete
      if (noisy && $urandom_range(24) == 0) send_word(MODE_FLUSH, 8'($urandom_range(255)));
      send_word(MODE_PIXEL, rand_mask());
    end
  endtask

  // width+1 drain words, some of them pixel words that act as flushes
  task automatic send_drain(int unsigned pix_pct);
    for (int unsigned i = 0; i <= eff_w; i++) begin
      if ($urandom_range(99) < pix_pct) send_word(MODE_PIXEL, 8'($urandom_range(255)));
      else send_word(MODE_FLUSH, 8'($urandom_range(255)));
    end
    frames++;
  endtask

  // all predicted words out, then let ignored words clear the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_pixel = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // erosion, with a premature flush and pixel words during the drain
    set_phase(PH_STEADY);
    set_config(OP_ERODE, 11'd3, 11'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(MODE_FLUSH, PIX_SET);
      send_word(MODE_PIXEL, ERODE_PAT[71 - 8*i -: 8]);
    end
    send_drain(100);

    // dilation
    wait_drained();
    set_config(OP_DILATE, 11'd4, 11'd3);
    for (int i = 0; i < 12; i++) send_word(MODE_PIXEL, DILATE_PAT[95 - 8*i -: 8]);
    send_drain(0);

    // zero sizes act as one
    wait_drained();
    set_config(OP_ERODE, 11'd0, 11'd0);
    send_word(MODE_PIXEL, PIX_SET);
    send_drain(0);

    // oversize height clamps to the tallest column
    wait_drained();
    set_config(OP_ERODE, 11'd1, 11'd2047);
    send_pixels(eff_h, 1'b0);
    send_drain(0);

    // register change inside the first row of a frame
    wait_drained();
    set_config(OP_ERODE, 11'd4, 11'd3);
    send_pixels(2, 1'b0);
    wait_drained();
    write_reg(REG_OP_SELECT, CFG_DW'(OP_DILATE));
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    cfg_we <= 1'b0;
    eff_h = 2;
    send_pixels(eff_w * eff_h - 2, 1'b0);
    send_drain(0);

    // random small frames, phase changes with every frame
    pixel_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < pixel_goal) begin
      set_phase(phase_t'(frames % 4));
      if ($urandom_range(1) == 0) begin
        op_raw = 1'($urandom_range(1));
        case ($urandom_range(49))
          0, 1, 2, 3, 4, 5: begin
            w_raw = 11'($urandom_range(9, 40));
            h_raw = 11'($urandom_range(2, 8));
          end
          default: begin
            w_raw = 11'($urandom_range(1, 8));
            h_raw = 11'($urandom_range(1, 6));
          end
        endcase
        wait_drained();
        set_config(op_raw, w_raw, h_raw);
      end
      send_pixels(eff_w * eff_h, 1'b1);
      send_drain(25);
      // stray flush after the frame closed, ignored
      if ($urandom_range(9) == 0) send_word(MODE_FLUSH, 8'($urandom_range(255)));
    end

    wait_drained();
    $display("tb: %0d frames, %0d pixel words, %0d flush words, %0d results checked",
             frames, pixels_sent, flushes_sent, result_count);
    $display("tb: erosion and dilation, zero sizes, height clamped to 1024, mid-frame change");
    if (fail_count == 0 && open_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
